FILE: src/hrt_pkg.sv
// ----------------------------------------------------------------------------
// hrt_pkg: shared types and constants for the HDR resolve / tonemap block
// Fixed-point constants, item and request structs, sequencer states and the
// gamma threshold table built at elaboration.
// ----------------------------------------------------------------------------
package hrt_pkg;

  localparam int FRAC   = 16;
  localparam int GIB    = 12;
  localparam int MPL    = 22;
  localparam int SUM_W  = 40;
  localparam int EXP_W  = 20;
  localparam int FC_W   = 16;
  localparam int TOT_W  = 42;
  localparam int CNT_W  = MPL + 1;
  localparam int DIVN_W = 64;
  localparam int DIVD_W = 48;
  localparam int DIVC_W = 7;
  localparam int GIDX_W = GIB + 1;

  localparam logic [EXP_W-1:0] ONE_Q     = EXP_W'(64'd1 << FRAC);
  localparam logic [15:0]      K_LUM_R   = 16'(((64'd299 << FRAC) + 64'd500) / 64'd1000);
  localparam logic [15:0]      K_LUM_G   = 16'(((64'd587 << FRAC) + 64'd500) / 64'd1000);
  localparam logic [15:0]      K_LUM_B   = 16'(((64'd114 << FRAC) + 64'd500) / 64'd1000);
  localparam logic [15:0]      K_MILLI   = 16'(((64'd1 << FRAC) + 64'd500) / 64'd1000);
  localparam logic [15:0]      K_TENTH   = 16'(((64'd1 << FRAC) + 64'd5) / 64'd10);
  localparam logic [EXP_W-1:0] K_TEN     = EXP_W'(64'd10 << FRAC);
  localparam logic [17:0]      K_A251    = 18'(((64'd251 << FRAC) + 64'd50) / 64'd100);
  localparam logic [17:0]      K_A3      = 18'(((64'd3 << FRAC) + 64'd50) / 64'd100);
  localparam logic [17:0]      K_A243    = 18'(((64'd243 << FRAC) + 64'd50) / 64'd100);
  localparam logic [17:0]      K_A59     = 18'(((64'd59 << FRAC) + 64'd50) / 64'd100);
  localparam logic [17:0]      K_A14     = 18'(((64'd14 << FRAC) + 64'd50) / 64'd100);
  localparam logic [24:0]      SAT_CH    = 25'(64'd1 << (FRAC + 8));
  localparam logic [20:0]      SAT_X     = 21'(64'd1 << (FRAC + 4));

  localparam logic [1:0] CFG_FRAME_COUNT = 2'd0;
  localparam logic [1:0] CFG_MANUAL_EXP  = 2'd1;
  localparam logic [1:0] CFG_AUTO_EN     = 2'd2;
  localparam logic [1:0] CFG_TARGET      = 2'd3;

  typedef enum logic [1:0] {
    ACT_MEAS = 2'd0,
    ACT_FIN  = 2'd1,
    ACT_CONV = 2'd2,
    ACT_NOP  = 2'd3
  } act_t;

  typedef struct packed {
    act_t             act;
    logic [SUM_W-1:0] sum_r;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_b;
  } item_t;

  typedef struct packed {
    logic [FC_W-1:0]  frame_count;
    logic [EXP_W-1:0] manual_exp;
    logic             auto_en;
    logic [EXP_W-1:0] target;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] num;
    logic [DIVC_W-1:0] bits;
    logic [DIVD_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVN_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_AVG_GO, S_AVG_WAIT, S_LUM_ACC, S_LUM_CHK,
    S_FIN_GO, S_FIN_AVG_WAIT, S_FIN_EXP_GO, S_FIN_EXP_WAIT,
    S_MUL_LO, S_MUL_HI, S_ACES_A, S_ACES_B, S_ACES_C, S_ACES_WAIT,
    S_GAMMA, S_DONE
  } bst_t;

  typedef logic [GIDX_W-1:0] gthr_t [256];

  function automatic logic [191:0] gpow(input logic [191:0] b, input int n);
    logic [191:0] p;
    p = 192'd1;
    for (int k = 0; k < n; k++) p = p * b;
    return p;
  endfunction

  // t[v]: smallest index whose gamma output reaches v
  function automatic gthr_t gamma_thr_f();
    gthr_t        t;
    logic [191:0] lhs;
    logic [191:0] k255;
    int           lo;
    int           hi;
    int           mid;
    k255 = gpow(192'd255, 11);
    t[0] = '0;
    for (int v = 1; v < 256; v++) begin
      lhs = gpow(192'(v), 11) << (5 * GIB);
      lo  = 0;
      hi  = 1 << GIB;
      for (int s = 0; s <= GIB; s++) begin
        if (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (lhs <= gpow(192'(mid), 5) * k255) hi = mid;
          else lo = mid + 1;
        end
      end
      t[v] = GIDX_W'(lo);
    end
    return t;
  endfunction

  localparam gthr_t GAMMA_THR = gamma_thr_f();

endpackage

FILE: src/hrt_front.sv
// ----------------------------------------------------------------------------
// hrt_front: request intake
// Two-entry queue that accepts requests, decodes the action and hands them
// to the sequencer.
// ----------------------------------------------------------------------------
module hrt_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  input  logic [1:0]                in_action,
  input  logic [hrt_pkg::SUM_W-1:0] in_sum_red,
  input  logic [hrt_pkg::SUM_W-1:0] in_sum_green,
  input  logic [hrt_pkg::SUM_W-1:0] in_sum_blue,
  output logic                      in_full,
  output logic                      item_valid,
  output hrt_pkg::item_t            item,
  input  logic                      item_take
);

  hrt_pkg::item_t q_r [2];
  logic           wp_r, wp_nxt;
  logic           rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           wr_en;
  logic           rd_en;
  hrt_pkg::act_t  act;

  // every 2-bit code is an act_t member
  assign act = hrt_pkg::act_t'(in_action);

  assign in_full    = (cnt_r == 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rp_r];
  assign wr_en      = in_push && !in_full;
  assign rd_en      = item_take && item_valid;

  always_comb begin
    wp_nxt  = wr_en ? !wp_r : wp_r;
    rp_nxt  = rd_en ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wp_r] <= '{act: act, sum_r: in_sum_red, sum_g: in_sum_green, sum_b: in_sum_blue};
    end
  end

endmodule

FILE: src/hrt_div.sv
// ----------------------------------------------------------------------------
// hrt_div: shared serial divider
// Restoring divider, one quotient bit per cycle; numerator is top-aligned.
// ----------------------------------------------------------------------------
module hrt_div (
  input  logic              clk,
  input  logic              rst_n,
  input  hrt_pkg::div_req_t req,
  output hrt_pkg::div_rsp_t rsp
);

  logic [hrt_pkg::DIVN_W-1:0] num_r, num_nxt;
  logic [hrt_pkg::DIVD_W-1:0] den_r, den_nxt;
  logic [hrt_pkg::DIVD_W-1:0] rem_r, rem_nxt;
  logic [hrt_pkg::DIVN_W-1:0] q_r, q_nxt;
  logic [hrt_pkg::DIVC_W-1:0] cnt_r, cnt_nxt;
  logic                       done_r, done_nxt;
  logic [hrt_pkg::DIVD_W:0]   rem_sh;
  logic [hrt_pkg::DIVD_W:0]   diff;
  logic                       ge;

  assign rem_sh = {rem_r, num_r[hrt_pkg::DIVN_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign ge     = (rem_sh >= {1'b0, den_r});

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      num_nxt = req.num;
      den_nxt = req.den;
      rem_nxt = '0;
      q_nxt   = '0;
      cnt_nxt = req.bits;
    end else if (cnt_r != '0) begin
      num_nxt  = {num_r[hrt_pkg::DIVN_W-2:0], 1'b0};
      rem_nxt  = ge ? diff[hrt_pkg::DIVD_W-1:0] : rem_sh[hrt_pkg::DIVD_W-1:0];
      q_nxt    = {q_r[hrt_pkg::DIVN_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == hrt_pkg::DIVC_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = q_r;

endmodule

FILE: src/hrt_back.sv
// ----------------------------------------------------------------------------
// hrt_back: execution sequencer
// Runs measure, finish, convert and no-op requests through the shared divider,
// multipliers and gamma search, and holds the result register.
// ----------------------------------------------------------------------------
module hrt_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hrt_pkg::cfg_t             cfg,
  input  logic                      item_valid,
  input  hrt_pkg::item_t            item,
  output logic                      item_take,
  output hrt_pkg::div_req_t         div_req,
  input  hrt_pkg::div_rsp_t         div_rsp,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [31:0]               out_packed_color,
  output logic [hrt_pkg::EXP_W-1:0] out_exposure_in_use
);

  hrt_pkg::bst_t state_r, state_nxt;
  hrt_pkg::item_t item_r, item_nxt;
  logic [1:0]                  ch_r, ch_nxt;
  logic [hrt_pkg::TOT_W-1:0]   avg_r, avg_nxt;
  logic [hrt_pkg::TOT_W-1:0]   acc_r, acc_nxt;
  logic [hrt_pkg::TOT_W-1:0]   total_r, total_nxt;
  logic [hrt_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [hrt_pkg::EXP_W-1:0]   mexp_r, mexp_nxt;
  logic [37:0]                 prod_r, prod_nxt;
  logic [20:0]                 x_r, x_nxt;
  logic [22:0]                 t1_r, t1_nxt;
  logic [22:0]                 t2_r, t2_nxt;
  logic [43:0]                 num_r, num_nxt;
  logic [43:0]                 den_r, den_nxt;
  logic [hrt_pkg::GIDX_W-1:0]  idx_r, idx_nxt;
  logic [7:0]                  v_r, v_nxt;
  logic [2:0]                  bit_r, bit_nxt;
  logic [7:0]                  chan_r [3];
  logic [7:0]                  chan_nxt [3];
  logic                        res_valid_r, res_valid_nxt;
  logic [31:0]                 res_packed_r, res_packed_nxt;
  logic [hrt_pkg::EXP_W-1:0]   res_expo_r, res_expo_nxt;

  logic [hrt_pkg::SUM_W-1:0]   sum_sel;
  logic [hrt_pkg::FC_W-1:0]    fc_eff;
  logic [hrt_pkg::EXP_W-1:0]   expo_now;
  logic [24:0]                 sat;
  logic [15:0]                 k_lum;
  logic [40:0]                 lum_term;
  logic [25:0]                 lum;
  logic                        lum_ok;
  logic [35:0]                 e_raw;
  logic [37:0]                 hi_p;
  logic [55:0]                 p_full;
  logic [39:0]                 xs;
  logic [38:0]                 m1;
  logic [38:0]                 m2;
  logic [7:0]                  cand;
  logic [7:0]                  v_new;
  logic                        res_load;

  always_comb begin
    case (ch_r)
      2'd0:    begin sum_sel = item_r.sum_r; k_lum = hrt_pkg::K_LUM_R; end
      2'd1:    begin sum_sel = item_r.sum_g; k_lum = hrt_pkg::K_LUM_G; end
      default: begin sum_sel = item_r.sum_b; k_lum = hrt_pkg::K_LUM_B; end
    endcase
  end

  assign fc_eff   = (cfg.frame_count == '0) ? hrt_pkg::FC_W'(1) : cfg.frame_count;
  assign expo_now = cfg.auto_en ? mexp_r : cfg.manual_exp;
  assign sat      = (avg_r > hrt_pkg::TOT_W'(hrt_pkg::SAT_CH)) ? hrt_pkg::SAT_CH : avg_r[24:0];
  assign lum_term = k_lum * sat;
  assign lum      = acc_r[hrt_pkg::TOT_W-1:hrt_pkg::FRAC];
  assign lum_ok   = (lum > 26'(hrt_pkg::K_MILLI)) && (lum < 26'(hrt_pkg::K_TEN))
                 && (count_r < hrt_pkg::CNT_W'(64'd1 << hrt_pkg::MPL));
  assign e_raw    = div_rsp.quo[35:0];
  assign hi_p     = avg_r[35:18] * expo_now;
  assign p_full   = {hi_p, 18'b0} + 56'(prod_r);
  assign xs       = p_full[55:16];
  assign m1       = hrt_pkg::K_A251 * x_r;
  assign m2       = hrt_pkg::K_A243 * x_r;
  assign cand     = v_r | (8'd1 << bit_r);
  assign v_new    = (hrt_pkg::GAMMA_THR[cand] <= idx_r) ? cand : v_r;
  assign res_load = !res_valid_r || out_pop;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hrt_pkg::S_IDLE: begin
        if (item_valid) begin
          case (item.act)
            hrt_pkg::ACT_MEAS: state_nxt = hrt_pkg::S_AVG_GO;
            hrt_pkg::ACT_CONV: state_nxt = hrt_pkg::S_AVG_GO;
            hrt_pkg::ACT_FIN:  state_nxt = hrt_pkg::S_FIN_GO;
            default:           state_nxt = hrt_pkg::S_DONE;
          endcase
        end
      end
      hrt_pkg::S_AVG_GO: state_nxt = hrt_pkg::S_AVG_WAIT;
      hrt_pkg::S_AVG_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = (item_r.act == hrt_pkg::ACT_MEAS) ? hrt_pkg::S_LUM_ACC : hrt_pkg::S_MUL_LO;
        end
      end
      hrt_pkg::S_LUM_ACC: state_nxt = (ch_r == 2'd2) ? hrt_pkg::S_LUM_CHK : hrt_pkg::S_AVG_GO;
      hrt_pkg::S_LUM_CHK: state_nxt = hrt_pkg::S_DONE;
      hrt_pkg::S_FIN_GO:  state_nxt = (count_r == '0) ? hrt_pkg::S_DONE : hrt_pkg::S_FIN_AVG_WAIT;
      hrt_pkg::S_FIN_AVG_WAIT: if (div_rsp.done) state_nxt = hrt_pkg::S_FIN_EXP_GO;
      hrt_pkg::S_FIN_EXP_GO:   state_nxt = hrt_pkg::S_FIN_EXP_WAIT;
      hrt_pkg::S_FIN_EXP_WAIT: if (div_rsp.done) state_nxt = hrt_pkg::S_DONE;
      hrt_pkg::S_MUL_LO: state_nxt = hrt_pkg::S_MUL_HI;
      hrt_pkg::S_MUL_HI: state_nxt = hrt_pkg::S_ACES_A;
      hrt_pkg::S_ACES_A: state_nxt = hrt_pkg::S_ACES_B;
      hrt_pkg::S_ACES_B: state_nxt = hrt_pkg::S_ACES_C;
      hrt_pkg::S_ACES_C: state_nxt = (num_r >= den_r) ? hrt_pkg::S_GAMMA : hrt_pkg::S_ACES_WAIT;
      hrt_pkg::S_ACES_WAIT: if (div_rsp.done) state_nxt = hrt_pkg::S_GAMMA;
      hrt_pkg::S_GAMMA: begin
        if (bit_r == 3'd0) begin
          state_nxt = (ch_r == 2'd2) ? hrt_pkg::S_DONE : hrt_pkg::S_AVG_GO;
        end
      end
      hrt_pkg::S_DONE: if (res_load) state_nxt = hrt_pkg::S_IDLE;
      default: state_nxt = hrt_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    item_take      = 1'b0;
    div_req        = '0;
    item_nxt       = item_r;
    ch_nxt         = ch_r;
    avg_nxt        = avg_r;
    acc_nxt        = acc_r;
    total_nxt      = total_r;
    count_nxt      = count_r;
    mexp_nxt       = mexp_r;
    prod_nxt       = prod_r;
    x_nxt          = x_r;
    t1_nxt         = t1_r;
    t2_nxt         = t2_r;
    num_nxt        = num_r;
    den_nxt        = den_r;
    idx_nxt        = idx_r;
    v_nxt          = v_r;
    bit_nxt        = bit_r;
    chan_nxt       = chan_r;
    res_valid_nxt  = res_valid_r;
    res_packed_nxt = res_packed_r;
    res_expo_nxt   = res_expo_r;
    if (out_pop && res_valid_r) res_valid_nxt = 1'b0;
    case (state_r)
      hrt_pkg::S_IDLE: begin
        item_take = item_valid;
        item_nxt  = item;
        ch_nxt    = 2'd0;
        acc_nxt   = '0;
      end
      hrt_pkg::S_AVG_GO: begin
        div_req = '{start: 1'b1, num: {sum_sel, 24'b0}, bits: hrt_pkg::DIVC_W'(40),
                    den: hrt_pkg::DIVD_W'(fc_eff)};
      end
      hrt_pkg::S_AVG_WAIT: begin
        if (div_rsp.done) avg_nxt = div_rsp.quo[hrt_pkg::TOT_W-1:0];
      end
      hrt_pkg::S_LUM_ACC: begin
        acc_nxt = acc_r + hrt_pkg::TOT_W'(lum_term);
        ch_nxt  = ch_r + 2'd1;
      end
      hrt_pkg::S_LUM_CHK: begin
        if (lum_ok) begin
          total_nxt = total_r + hrt_pkg::TOT_W'(lum);
          count_nxt = count_r + 1'b1;
        end
      end
      hrt_pkg::S_FIN_GO: begin
        if (count_r == '0) begin
          mexp_nxt  = hrt_pkg::ONE_Q;
          total_nxt = '0;
        end else begin
          div_req = '{start: 1'b1, num: {total_r, 22'b0}, bits: hrt_pkg::DIVC_W'(42),
                      den: hrt_pkg::DIVD_W'(count_r)};
        end
      end
      hrt_pkg::S_FIN_AVG_WAIT: begin
        if (div_rsp.done) avg_nxt = div_rsp.quo[hrt_pkg::TOT_W-1:0];
      end
      hrt_pkg::S_FIN_EXP_GO: begin
        div_req = '{start: 1'b1, num: {cfg.target, 44'b0}, bits: hrt_pkg::DIVC_W'(36),
                    den: hrt_pkg::DIVD_W'(avg_r) + hrt_pkg::DIVD_W'(hrt_pkg::K_MILLI)};
      end
      hrt_pkg::S_FIN_EXP_WAIT: begin
        if (div_rsp.done) begin
          if (e_raw < 36'(hrt_pkg::K_TENTH)) mexp_nxt = hrt_pkg::EXP_W'(hrt_pkg::K_TENTH);
          else if (e_raw > 36'(hrt_pkg::K_TEN)) mexp_nxt = hrt_pkg::K_TEN;
          else mexp_nxt = e_raw[hrt_pkg::EXP_W-1:0];
          total_nxt = '0;
          count_nxt = '0;
        end
      end
      hrt_pkg::S_MUL_LO: prod_nxt = avg_r[17:0] * expo_now;
      hrt_pkg::S_MUL_HI: begin
        if (expo_now == '0) x_nxt = '0;
        else if (avg_r[39:36] != 4'd0) x_nxt = hrt_pkg::SAT_X;
        else if (xs > 40'(hrt_pkg::SAT_X)) x_nxt = hrt_pkg::SAT_X;
        else x_nxt = xs[20:0];
      end
      hrt_pkg::S_ACES_A: begin
        t1_nxt = m1[38:16] + 23'(hrt_pkg::K_A3);
        t2_nxt = m2[38:16] + 23'(hrt_pkg::K_A59);
      end
      hrt_pkg::S_ACES_B: begin
        num_nxt = x_r * t1_r;
        den_nxt = x_r * t2_r + {10'b0, hrt_pkg::K_A14, 16'b0};
      end
      hrt_pkg::S_ACES_C: begin
        v_nxt   = 8'd0;
        bit_nxt = 3'd7;
        if (num_r >= den_r) begin
          idx_nxt = hrt_pkg::GIDX_W'(64'd1 << hrt_pkg::GIB);
        end else begin
          div_req = '{start: 1'b1, num: {num_r, 20'b0}, bits: hrt_pkg::DIVC_W'(60),
                      den: hrt_pkg::DIVD_W'(den_r)};
        end
      end
      hrt_pkg::S_ACES_WAIT: begin
        if (div_rsp.done) idx_nxt = div_rsp.quo[16:4];
      end
      hrt_pkg::S_GAMMA: begin
        v_nxt   = v_new;
        bit_nxt = bit_r - 3'd1;
        if (bit_r == 3'd0) begin
          chan_nxt[ch_r] = v_new;
          ch_nxt         = ch_r + 2'd1;
        end
      end
      hrt_pkg::S_DONE: begin
        if (res_load) begin
          res_valid_nxt  = 1'b1;
          res_packed_nxt = (item_r.act == hrt_pkg::ACT_CONV)
                         ? {chan_r[0], chan_r[1], chan_r[2], 8'hFF} : 32'd0;
          res_expo_nxt   = expo_now;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hrt_pkg::S_IDLE;
      total_r     <= '0;
      count_r     <= '0;
      mexp_r      <= hrt_pkg::ONE_Q;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      count_r     <= count_nxt;
      mexp_r      <= mexp_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    ch_r         <= ch_nxt;
    avg_r        <= avg_nxt;
    acc_r        <= acc_nxt;
    prod_r       <= prod_nxt;
    x_r          <= x_nxt;
    t1_r         <= t1_nxt;
    t2_r         <= t2_nxt;
    num_r        <= num_nxt;
    den_r        <= den_nxt;
    idx_r        <= idx_nxt;
    v_r          <= v_nxt;
    bit_r        <= bit_nxt;
    chan_r       <= chan_nxt;
    res_packed_r <= res_packed_nxt;
    res_expo_r   <= res_expo_nxt;
  end

  assign out_empty           = !res_valid_r;
  assign out_packed_color    = res_packed_r;
  assign out_exposure_in_use = res_expo_r;

endmodule

FILE: src/hdr_resolve_tonemap_auto_exposure.sv
// ----------------------------------------------------------------------------
// hdr_resolve_tonemap_auto_exposure: HDR resolve, auto exposure, ACES tonemap
// Sequence: action 3 is a no-op; measure runs per channel a frame divide and
//   a luminance step, then the pixel check; finish an average and an exposure
//   divide (neither with no counted pixel); convert per channel a frame divide,
//   fit setup, a fit divide (skipped when saturated) and an 8-step gamma search.
// Throughput: one request at a time; an unpopped result holds the next request.
// Reset: synchronous active low; registers to defaults, totals cleared,
//   measured exposure 1.0, intake queue and result register empty.
// ----------------------------------------------------------------------------
module hdr_resolve_tonemap_auto_exposure (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [1:0]                in_action,
  input  logic [hrt_pkg::SUM_W-1:0] in_sum_red,
  input  logic [hrt_pkg::SUM_W-1:0] in_sum_green,
  input  logic [hrt_pkg::SUM_W-1:0] in_sum_blue,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [31:0]               out_packed_color,
  output logic [hrt_pkg::EXP_W-1:0] out_exposure_in_use,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [hrt_pkg::EXP_W-1:0] cfg_data
);

  hrt_pkg::cfg_t     cfg_r, cfg_nxt;
  logic              item_valid;
  hrt_pkg::item_t    item;
  logic              item_take;
  hrt_pkg::div_req_t div_req;
  hrt_pkg::div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        hrt_pkg::CFG_FRAME_COUNT: cfg_nxt.frame_count = cfg_data[hrt_pkg::FC_W-1:0];
        hrt_pkg::CFG_MANUAL_EXP:  cfg_nxt.manual_exp  = cfg_data;
        hrt_pkg::CFG_AUTO_EN:     cfg_nxt.auto_en     = cfg_data[0];
        hrt_pkg::CFG_TARGET:      cfg_nxt.target      = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_count <= hrt_pkg::FC_W'(1);
      cfg_r.manual_exp  <= hrt_pkg::ONE_Q;
      cfg_r.auto_en     <= 1'b0;
      cfg_r.target      <= hrt_pkg::EXP_W'(((64'd18 << hrt_pkg::FRAC) + 64'd50) / 64'd100);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hrt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_action    (in_action),
    .in_sum_red   (in_sum_red),
    .in_sum_green (in_sum_green),
    .in_sum_blue  (in_sum_blue),
    .in_full      (in_full),
    .item_valid   (item_valid),
    .item         (item),
    .item_take    (item_take)
  );

  hrt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  hrt_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .item_valid          (item_valid),
    .item                (item),
    .item_take           (item_take),
    .div_req             (div_req),
    .div_rsp             (div_rsp),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_packed_color    (out_packed_color),
    .out_exposure_in_use (out_exposure_in_use)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !in_full && out_empty)
    else $error("queues not empty after reset");

  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_packed_color != 32'd0 |-> out_packed_color[7:0] == 8'hFF)
    else $error("converted pixel without opaque alpha");

  a_full_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> item_valid)
    else $error("intake full but no request offered to sequencer");

endmodule
